>>> rtl/core/gdlm_pkg.sv
// Shared constants, field layout and helpers for the detection list merger.
// No dependencies; used by greedy_detection_list_merger_core.
package gdlm_pkg;

  localparam int MAX_PERSONS_DEF = 16;

  localparam int COORD_W  = 15;
  localparam int COLOR_W  = 8;
  localparam int POS_LSB  = 0;
  localparam int COL_LSB  = 3 * COORD_W;
  localparam int BOX_LSB  = COL_LSB + 3 * COLOR_W;
  localparam int ENTRY_W  = BOX_LSB + 3 * COORD_W;
  localparam int TDATA_W  = ((ENTRY_W + 7) / 8) * 8;

  localparam int CLIM_W   = 18;
  localparam int DIST_W   = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CLIM_W-1:0] CLIM_RST  = 18'd5625;
  localparam logic [DIST_W-1:0] LOOSE_RST = 31'd250000;
  localparam logic [DIST_W-1:0] TIGHT_RST = 31'd40000;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOSE_DIST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIGHT_DIST  = 2'd2;

  // floor((a + b) / 2) for signed coordinates
  function automatic logic [COORD_W-1:0] floor_half(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction

endpackage

>>> rtl/core/greedy_detection_list_merger_core.sv
// Greedy detection list merger: list memories, match scan and result queue.
// Depends on gdlm_pkg.
//
// Usage
//   s_*   : detection stream. tdata = position x,y,z, colour r,g,b, box x,y,z;
//           tuser[0] = list (0 = A, 1 = B), tuser[1] = carries a person;
//           tlast = end of frame, which starts the merge.
//   m_*   : result stream. tuser[0] = result valid, tuser[1] = merged pair;
//           tlast = final result of the frame.
//   cfg_* : register writes, index 0 colour limit, 1 loose, 2 tight distance.
// Throughput and scan order
//   Loading takes one transaction per cycle while idle. The end-of-frame
//   transaction blocks the input until the frame's last result has entered
//   the output register. The match scan reads each A entry, then tests each
//   unused B entry in turn (memory read, squaring, compare) and skips used
//   ones; the unmatched sweeps then emit the unused A entries and then the
//   unused B entries, skip used ones and close each list.
// Reset clears counts, flags and both output stages and restores register
//   defaults; list memories are not cleared. A stalled receiver holds the
//   output register and, once the one-deep pending stage is full, the scan.
module greedy_detection_list_merger_core #(
  parameter int MAX_PERSONS = gdlm_pkg::MAX_PERSONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gdlm_pkg::TDATA_W-1:0]     s_tdata,  // x,y,z,r,g,b,box x,y,z, zero pad
  input  logic [1:0]                       s_tuser,  // source_list, carries_person
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gdlm_pkg::TDATA_W-1:0]     m_tdata,  // x,y,z,r,g,b,box x,y,z, zero pad
  output logic [1:0]                       m_tuser,  // result_valid, was_merged
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gdlm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gdlm_pkg::DIST_W-1:0]      cfg_data
);

  localparam int EW    = gdlm_pkg::ENTRY_W;
  localparam int CW    = gdlm_pkg::COORD_W;
  localparam int CNT_W = $clog2(MAX_PERSONS + 1);
  localparam int IDX_W = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;

  typedef enum logic [3:0] {
    IDLE, START, M_RDA, M_RDB, M_CALC, M_CMP, U_A, U_AW, U_B, U_BW, FLUSH
  } state_t;

  state_t state;

  // configuration
  logic [gdlm_pkg::CLIM_W-1:0] color_limit;
  logic [gdlm_pkg::DIST_W-1:0] loose_dist;
  logic [gdlm_pkg::DIST_W-1:0] tight_dist;

  logic [CNT_W-1:0] count_a, count_b, i, j;
  logic [MAX_PERSONS-1:0] a_used, b_used;

  // list memories
  logic [EW-1:0] a_mem [MAX_PERSONS];
  logic [EW-1:0] b_mem [MAX_PERSONS];
  logic [EW-1:0] a_rd, b_rd;
  logic a_we, b_we, a_re, b_re;

  // pending result and output register
  logic          p_valid;
  logic [EW-1:0] p_data;
  logic [1:0]    p_user;
  logic [EW-1:0] o_data;
  logic [1:0]    o_user;
  logic          o_last;
  logic          o_load;

  // squares
  logic [gdlm_pkg::DIST_W-1:0] dx2, dy2;
  logic [15:0] dc2 [3];

  logic s_acc, stall, produce, match;
  logic [EW-1:0] r_data, pair_data;
  logic [1:0]    r_user;
  logic [31:0]   plane_sq;
  logic [gdlm_pkg::CLIM_W-1:0] col;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign m_tdata   = {{(gdlm_pkg::TDATA_W - EW){1'b0}}, o_data};
  assign m_tuser   = o_user;

  assign a_we = s_acc && s_tuser[1] && !s_tuser[0] && (count_a < CNT_W'(MAX_PERSONS));
  assign b_we = s_acc && s_tuser[1] &&  s_tuser[0] && (count_b < CNT_W'(MAX_PERSONS));

  assign a_re = ((state == M_RDA) && (i != count_a)) ||
                ((state == U_A) && (i != count_a) && !a_used[i[IDX_W-1:0]]);
  assign b_re = ((state == M_RDB) && (j != count_b) && !b_used[j[IDX_W-1:0]]) ||
                ((state == U_B) && (j != count_b) && !b_used[j[IDX_W-1:0]]);

  always_ff @(posedge clk) begin
    if (a_we) a_mem[count_a[IDX_W-1:0]] <= s_tdata[EW-1:0];
    if (b_we) b_mem[count_b[IDX_W-1:0]] <= s_tdata[EW-1:0];
    if (a_re) a_rd <= a_mem[i[IDX_W-1:0]];
    if (b_re) b_rd <= b_mem[j[IDX_W-1:0]];
  end

  // pair: averaged position and box, colour of A
  always_comb begin
    pair_data = a_rd;
    for (int k = 0; k < 3; k++) begin
      pair_data[gdlm_pkg::POS_LSB + k*CW +: CW] =
        gdlm_pkg::floor_half(a_rd[gdlm_pkg::POS_LSB + k*CW +: CW],
                             b_rd[gdlm_pkg::POS_LSB + k*CW +: CW]);
      pair_data[gdlm_pkg::BOX_LSB + k*CW +: CW] =
        gdlm_pkg::floor_half(a_rd[gdlm_pkg::BOX_LSB + k*CW +: CW],
                             b_rd[gdlm_pkg::BOX_LSB + k*CW +: CW]);
    end
  end

  assign plane_sq = {1'b0, dx2} + {1'b0, dy2};
  assign col   = gdlm_pkg::CLIM_W'({2'b0, dc2[0]} + {2'b0, dc2[1]} + {2'b0, dc2[2]});
  assign match = ((col < color_limit) && (plane_sq < {1'b0, loose_dist})) ||
                 (plane_sq < {1'b0, tight_dist});

  assign stall = p_valid && m_tvalid && !m_tready;

  // output register takes the pending result on a new result or at frame end
  assign o_load = (produce && p_valid) || ((state == FLUSH) && (!m_tvalid || m_tready));

  always_comb begin
    produce = 1'b0;
    r_data  = a_rd;
    r_user  = 2'b01;
    case (state)
      START:   begin
        produce = (count_a == '0) && (count_b == '0);
        r_data  = '0;
        r_user  = 2'b00;
      end
      M_CMP:   begin
        produce = match && !stall;
        r_data  = pair_data;
        r_user  = 2'b11;
      end
      U_AW:    produce = !stall;
      U_BW:    begin
        produce = !stall;
        r_data  = b_rd;
      end
      default: produce = 1'b0;
    endcase
  end

  // squaring stage
  always_ff @(posedge clk) begin
    logic signed [CW:0] dx, dy;
    logic signed [8:0]  dc;
    dx  = {a_rd[CW-1], a_rd[CW-1:0]} - {b_rd[CW-1], b_rd[CW-1:0]};
    dy  = {a_rd[2*CW-1], a_rd[2*CW-1:CW]} - {b_rd[2*CW-1], b_rd[2*CW-1:CW]};
    dx2 <= gdlm_pkg::DIST_W'(dx * dx);
    dy2 <= gdlm_pkg::DIST_W'(dy * dy);
    for (int k = 0; k < 3; k++) begin
      dc = {1'b0, a_rd[gdlm_pkg::COL_LSB + 8*k +: 8]} -
           {1'b0, b_rd[gdlm_pkg::COL_LSB + 8*k +: 8]};
      dc2[k] <= 16'(dc * dc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      color_limit <= gdlm_pkg::CLIM_RST;
      loose_dist  <= gdlm_pkg::LOOSE_RST;
      tight_dist  <= gdlm_pkg::TIGHT_RST;
      count_a     <= '0;
      count_b     <= '0;
      i           <= '0;
      j           <= '0;
      a_used      <= '0;
      b_used      <= '0;
      p_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
      m_tlast     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gdlm_pkg::REG_COLOR_LIMIT: color_limit <= cfg_data[gdlm_pkg::CLIM_W-1:0];
          gdlm_pkg::REG_LOOSE_DIST:  loose_dist  <= cfg_data;
          gdlm_pkg::REG_TIGHT_DIST:  tight_dist  <= cfg_data;
          default: ;
        endcase
      end

      if (o_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      // new result: older pending one moves to the output, not last
      if (produce) begin
        if (p_valid) begin
          o_data   <= p_data;
          o_user   <= p_user;
          m_tlast  <= 1'b0;
        end
        p_data  <= r_data;
        p_user  <= r_user;
        p_valid <= 1'b1;
      end

      if (a_we) count_a <= count_a + 1'b1;
      if (b_we) count_b <= count_b + 1'b1;

      case (state)
        IDLE:   if (s_acc && s_tlast) state <= START;
        START:  begin
          a_used <= '0;
          b_used <= '0;
          i      <= '0;
          state  <= ((count_a == '0) && (count_b == '0)) ? FLUSH : M_RDA;
        end
        M_RDA:  begin
          j <= '0;
          if (i == count_a) begin
            i     <= '0;
            state <= U_A;
          end else begin
            state <= M_RDB;
          end
        end
        M_RDB:  begin
          if (j == count_b) begin
            i     <= i + 1'b1;
            state <= M_RDA;
          end else if (b_used[j[IDX_W-1:0]]) begin
            j <= j + 1'b1;
          end else begin
            state <= M_CALC;
          end
        end
        M_CALC: state <= M_CMP;
        M_CMP:  begin
          if (!match) begin
            j     <= j + 1'b1;
            state <= M_RDB;
          end else if (!stall) begin
            a_used[i[IDX_W-1:0]] <= 1'b1;
            b_used[j[IDX_W-1:0]] <= 1'b1;
            i     <= i + 1'b1;
            state <= M_RDA;
          end
        end
        U_A:    begin
          if (i == count_a) begin
            j     <= '0;
            state <= U_B;
          end else if (a_used[i[IDX_W-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            state <= U_AW;
          end
        end
        U_AW:   if (!stall) begin
          i     <= i + 1'b1;
          state <= U_A;
        end
        U_B:    begin
          if (j == count_b) begin
            state <= FLUSH;
          end else if (b_used[j[IDX_W-1:0]]) begin
            j <= j + 1'b1;
          end else begin
            state <= U_BW;
          end
        end
        U_BW:   if (!stall) begin
          j     <= j + 1'b1;
          state <= U_B;
        end
        FLUSH:  if (!m_tvalid || m_tready) begin
          o_data   <= p_data;
          o_user   <= p_user;
          m_tlast  <= 1'b1;
          p_valid  <= 1'b0;
          count_a  <= '0;
          count_b  <= '0;
          a_used   <= '0;
          b_used   <= '0;
          state    <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // every pair marks one entry in each list
  a_used_pairs: assert property (@(posedge clk) disable iff (rst)
    $countones(a_used) == $countones(b_used))
    else $error("used flags of the two lists disagree");

  idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !p_valid)
    else $error("result left pending while loading");

  count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CNT_W'(MAX_PERSONS)) && (count_b <= CNT_W'(MAX_PERSONS)))
    else $error("list count beyond capacity");

  flush_has_result: assert property (@(posedge clk) disable iff (rst)
    (state == FLUSH) |-> p_valid)
    else $error("frame end without a result");

endmodule

>>> tb/greedy_detection_list_merger_core_tb.sv
// Self-checking bench for greedy_detection_list_merger_core: drives detection frames,
// predicts the merged result stream in-bench and compares each result transaction.
// Depends on gdlm_pkg and the core RTL.
module greedy_detection_list_merger_core_tb;

  localparam int NP        = gdlm_pkg::MAX_PERSONS_DEF;
  localparam int ENTRY_W   = gdlm_pkg::ENTRY_W;
  localparam int TDATA_W   = gdlm_pkg::TDATA_W;
  localparam int COORD_W   = gdlm_pkg::COORD_W;
  localparam int COLOR_W   = gdlm_pkg::COLOR_W;
  localparam int POS_LSB   = gdlm_pkg::POS_LSB;
  localparam int COL_LSB   = gdlm_pkg::COL_LSB;
  localparam int BOX_LSB   = gdlm_pkg::BOX_LSB;
  localparam int CLIM_W    = gdlm_pkg::CLIM_W;
  localparam int DIST_W    = gdlm_pkg::DIST_W;
  localparam int CFG_IDX_W = gdlm_pkg::CFG_IDX_W;

  typedef struct packed {
    logic valid_person;
    logic merged;
    logic last;
    logic [ENTRY_W-1:0] entry;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0] cfg_data = '0;

  greedy_detection_list_merger_core dut (.*);

  initial forever #2 clk = ~clk;

  // in-bench copy of the block state
  logic [CLIM_W-1:0] lim_colour;
  logic [DIST_W-1:0] lim_loose, lim_tight;
  logic [ENTRY_W-1:0] list_a[NP], list_b[NP];
  int n_a, n_b;
  merge_result_t pending_results[$];

  int mismatches = 0;
  int tx_gaps = 1;           // 1 = random input idling enabled
  int rx_gaps = 1;
  int rx_hold = 0;           // cycles the receiver is held off

  function automatic int sx(logic [COORD_W-1:0] v);
    return $signed(v);
  endfunction

  function automatic logic [COORD_W-1:0] half_sum(logic [COORD_W-1:0] p, logic [COORD_W-1:0] q);
    int s;
    s = sx(p) + sx(q);
    return COORD_W'(s >>> 1);
  endfunction

  function automatic logic [COORD_W-1:0] crd(logic [ENTRY_W-1:0] e, int k, int lsb);
    return e[lsb + k*COORD_W +: COORD_W];
  endfunction

  function automatic bit same_person(logic [ENTRY_W-1:0] ea, logic [ENTRY_W-1:0] eb);
    longint dx, dy, dc, plane_sq, col;
    dx = sx(crd(ea, 0, POS_LSB)) - sx(crd(eb, 0, POS_LSB));
    dy = sx(crd(ea, 1, POS_LSB)) - sx(crd(eb, 1, POS_LSB));
    plane_sq = dx*dx + dy*dy;
    col = 0;
    for (int k = 0; k < 3; k++) begin
      dc = longint'(ea[COL_LSB + k*COLOR_W +: COLOR_W]) -
           longint'(eb[COL_LSB + k*COLOR_W +: COLOR_W]);
      col += dc*dc;
    end
    return (col < lim_colour && plane_sq < lim_loose) || plane_sq < lim_tight;
  endfunction

  // append one expected result transaction
  task automatic queue_result(merge_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // apply one accepted input transaction to the predictor
  task automatic predict_item(logic [ENTRY_W-1:0] e, bit to_b, bit person, bit eof);
    bit used_a[NP], used_b[NP];
    merge_result_t r;
    if (person) begin
      if (to_b && n_b < NP) list_b[n_b++] = e;
      else if (!to_b && n_a < NP) list_a[n_a++] = e;
    end
    if (!eof) return;
    if (n_a == 0 && n_b == 0) begin
      r = '0; r.last = 1'b1;
      queue_result(r);
      return;
    end
    used_a = '{default: 0}; used_b = '{default: 0};
    for (int i = 0; i < n_a; i++)
      for (int j = 0; j < n_b; j++)
        if (!used_b[j] && same_person(list_a[i], list_b[j])) begin
          used_a[i] = 1; used_b[j] = 1;
          r = '0; r.valid_person = 1; r.merged = 1;
          r.entry[COL_LSB +: 3*COLOR_W] = list_a[i][COL_LSB +: 3*COLOR_W];
          for (int k = 0; k < 3; k++) begin
            r.entry[POS_LSB + k*COORD_W +: COORD_W] =
              half_sum(crd(list_a[i], k, POS_LSB), crd(list_b[j], k, POS_LSB));
            r.entry[BOX_LSB + k*COORD_W +: COORD_W] =
              half_sum(crd(list_a[i], k, BOX_LSB), crd(list_b[j], k, BOX_LSB));
          end
          queue_result(r);
          break;
        end
    for (int i = 0; i < n_a; i++)
      if (!used_a[i]) begin
        r = '0; r.valid_person = 1; r.entry = list_a[i];
        queue_result(r);
      end
    for (int j = 0; j < n_b; j++)
      if (!used_b[j]) begin
        r = '0; r.valid_person = 1; r.entry = list_b[j];
        queue_result(r);
      end
    pending_results[pending_results.size()-1].last = 1'b1;
    n_a = 0; n_b = 0;
  endtask

  task automatic idle_tx();
    if (tx_gaps != 0 && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // one detection transaction; predictor updated at the accepting edge.
  // tvalid stays high for a following transaction and drops on idling.
  task automatic send_item(logic [ENTRY_W-1:0] e, bit to_b, bit person, bit eof);
    idle_tx();
    s_tvalid <= 1'b1;
    s_tdata <= TDATA_W'(e);
    s_tuser <= {person, to_b};
    s_tlast <= eof;
    do @(posedge clk); while (!s_tready);
    predict_item(e, to_b, person, eof);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gdlm_pkg::REG_COLOR_LIMIT: lim_colour = v[CLIM_W-1:0];
      gdlm_pkg::REG_LOOSE_DIST:  lim_loose = v;
      gdlm_pkg::REG_TIGHT_DIST:  lim_tight = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [ENTRY_W-1:0] make_entry(int x, int y, int z, int r, int g, int b,
                                                    int bx, int by, int bz);
    logic [ENTRY_W-1:0] e;
    e = '0;
    e[POS_LSB +: 3*COORD_W] = {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
    e[COL_LSB +: 3*COLOR_W] = {COLOR_W'(b), COLOR_W'(g), COLOR_W'(r)};
    e[BOX_LSB +: 3*COORD_W] = {COORD_W'(bz), COORD_W'(by), COORD_W'(bx)};
    return e;
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_entry();
    logic [ENTRY_W-1:0] e;
    e = ENTRY_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    return e;
  endfunction

  // perturb an entry a little so it tends to match its source
  function automatic logic [ENTRY_W-1:0] near_entry(logic [ENTRY_W-1:0] e);
    logic [ENTRY_W-1:0] n, rb;
    n = e;
    for (int k = 0; k < 2; k++)
      n[POS_LSB + k*COORD_W +: COORD_W] =
        crd(e, k, POS_LSB) + COORD_W'($urandom_range(0, 300) - 150);
    for (int k = 0; k < 3; k++)
      n[COL_LSB + k*COLOR_W +: COLOR_W] =
        e[COL_LSB + k*COLOR_W +: COLOR_W] + COLOR_W'($urandom_range(0, 40) - 20);
    rb = rand_entry();
    n[BOX_LSB +: 3*COORD_W] = rb[3*COORD_W-1:0];
    return n;
  endfunction

  // random frame: mostly paired A/B lists, some noise and bare markers
  task automatic send_frame(int na, int nb);
    logic [ENTRY_W-1:0] a_seen[$];
    int ia, ib;
    ia = 0; ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 9) == 0) send_item(rand_entry(), 1'($urandom_range(0, 1)), 0, 0);
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
        a_seen.insert(a_seen.size(), rand_entry());
        send_item(a_seen[$], 0, 1, 0); ia++;
      end else begin
        if (a_seen.size() != 0 && $urandom_range(0, 3) != 0)
          send_item(near_entry(a_seen[$urandom_range(0, a_seen.size()-1)]), 1, 1, 0);
        else send_item(rand_entry(), 1, 1, 0);
        ib++;
      end
    end
    if ($urandom_range(0, 1) == 0) send_item(rand_entry(), 1'($urandom_range(0, 1)), 1, 1);
    else send_item(rand_entry(), 1'($urandom_range(0, 1)), 0, 1);
  endtask

  // receiver: random back-pressure plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (rx_gaps != 0 && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    merge_result_t got, want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.valid_person = m_tuser[0];
        got.merged = m_tuser[1];
        got.last = m_tlast;
        got.entry = m_tdata[ENTRY_W-1:0];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  task automatic test_directed();
    logic [ENTRY_W-1:0] e;
    send_item('0, 0, 0, 1);                      // empty frame
    send_item(rand_entry(), 1, 0, 0);            // bare marker, ignored
    e = make_entry(-16384, 16383, -16384, 255, 0, 255, -16384, 16383, -1);
    send_item(e, 0, 1, 0);
    send_item(make_entry(-16383, 16383, 16383, 250, 5, 250, -16384, 16383, 0), 1, 1, 0);
    send_item(make_entry(100, 100, 0, 0, 0, 0, 1, 1, 1), 0, 1, 0);   // A only
    send_item(make_entry(16383, -16384, 0, 9, 9, 9, 3, 3, 3), 1, 1, 1); // B only, eof
    send_item(make_entry(0, 0, 0, 0, 0, 0, 5, 5, 5), 1, 1, 1);         // B-only frame
    send_item(make_entry(7, 7, 7, 1, 1, 1, 1, 1, 1), 0, 1, 1);         // A-only frame
    for (int i = 0; i < NP + 2; i++) send_item(rand_entry(), 0, 1, 0); // A overflow
    send_item(rand_entry(), 0, 0, 1);
  endtask

  task automatic test_full_lists();
    for (int i = 0; i < NP + 1; i++) send_item(rand_entry(), 1, 1, 0);
    send_frame(NP, 0);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    write_reg(gdlm_pkg::REG_COLOR_LIMIT, DIST_W'(0));
    write_reg(gdlm_pkg::REG_LOOSE_DIST, DIST_W'(0));
    write_reg(gdlm_pkg::REG_TIGHT_DIST, DIST_W'(0));
    send_frame(3, 3);
    wait_drained();
    write_reg(gdlm_pkg::REG_COLOR_LIMIT, DIST_W'(195075));
    write_reg(gdlm_pkg::REG_LOOSE_DIST, 31'h7FFFFFFF);
    write_reg(gdlm_pkg::REG_TIGHT_DIST, 31'h7FFFFFFF);
    send_frame(4, 5);
    wait_drained();
    write_reg(gdlm_pkg::REG_COLOR_LIMIT, DIST_W'(5625));
    write_reg(gdlm_pkg::REG_LOOSE_DIST, DIST_W'(250000));
    write_reg(gdlm_pkg::REG_TIGHT_DIST, DIST_W'(40000));
  endtask

  task automatic test_backpressure();
    rx_hold = 400;                               // receiver stalls while frames pile in
    send_frame(6, 6);
    send_frame(2, 3);
    wait_drained();                              // sender waits for every result
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 60) begin
      int na, nb;
      na = ($urandom_range(0, 9) == 0) ? NP : $urandom_range(0, 6);
      nb = ($urandom_range(0, 9) == 0) ? NP : $urandom_range(0, 6);
      send_frame(na, nb);
      sent += na + nb + 1;
      if (sent > 20 && sent < 40) begin
        wait_drained();
        write_reg(gdlm_pkg::REG_COLOR_LIMIT, DIST_W'($urandom_range(0, 195075)));
        write_reg(gdlm_pkg::REG_LOOSE_DIST, DIST_W'($urandom_range(0, 2000000)));
        write_reg(gdlm_pkg::REG_TIGHT_DIST, DIST_W'($urandom_range(0, 200000)));
      end
    end
    tx_gaps = 0; rx_gaps = 0;                    // closing stretch runs flat out
    send_frame(5, 5);
    send_frame(0, 4);
  endtask

  initial begin
    lim_colour = gdlm_pkg::CLIM_RST;
    lim_loose = gdlm_pkg::LOOSE_RST;
    lim_tight = gdlm_pkg::TIGHT_RST;
    n_a = 0; n_b = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_lists();
    test_register_extremes();
    test_backpressure();
    test_random_frames();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("greedy_detection_list_merger_core verification clean");
    end else begin
      $display("greedy_detection_list_merger_core verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("greedy_detection_list_merger_core verification failed");
    $finish;
  end

endmodule
